[design/lzw_encoder_12bit_defines.svh]
// Assertion macros used by the file that checks the LZW encoder.
`ifndef LZW_ENCODER_12BIT_DEFINES_SVH
`define LZW_ENCODER_12BIT_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define LZWE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define LZWE_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/lzwe_pkg.sv]
// Package with the request types and fixed constants of the LZW encoder.
`default_nettype none

package lzwe_pkg;

  localparam int unsigned RootCount = 256;
  localparam int unsigned EndCode   = 256;
  localparam int unsigned FirstFree = 257;
  localparam int unsigned MaxCodeW  = 16;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_req_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       start;
  } cmd_t;

  typedef struct packed {
    logic [MaxCodeW-1:0] code;
    logic                fin;
  } code_req_t;

endpackage

`default_nettype wire

[design/lzwe_front.sv]
// Input queue that accepts message bytes and marks the first byte of each message.
`default_nettype none

module lzwe_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire lzwe_pkg::in_req_t in_req_i,
  output logic                  cmd_valid_o,
  input  wire logic             cmd_ready_i,
  output lzwe_pkg::cmd_t        cmd_o
);

  lzwe_pkg::cmd_t q_mem [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           start_q, start_d;
  logic           push, pop;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    start_d  = start_q;
    if (push) begin
      wr_ptr_d = !wr_ptr_q;
      start_d  = in_req_i.in_last;
    end
    if (pop) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
      start_q  <= 1'b1;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      start_q  <= start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q].ch    <= in_req_i.in_byte;
      q_mem[wr_ptr_q].last  <= in_req_i.in_last;
      q_mem[wr_ptr_q].start <= start_q;
    end
  end

endmodule

`default_nettype wire

[design/lzwe_dict.sv]
// Dictionary engine: walks the trie for bytes after a message's first, adds entries and issues codes.
`default_nettype none

module lzwe_dict #(
  parameter int unsigned DICT_ENTRIES = 4096
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_ready_o,
  input  wire lzwe_pkg::cmd_t    cmd_i,
  output logic                   code_valid_o,
  input  wire logic              code_ready_i,
  output lzwe_pkg::code_req_t    code_o
);

  localparam int unsigned AW   = $clog2(DICT_ENTRIES);
  localparam int unsigned NF_W = AW + 1;
  localparam int unsigned RC   = lzwe_pkg::RootCount;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HEAD = 3'd1;
  localparam logic [2:0] ST_WALK = 3'd2;
  localparam logic [2:0] ST_MISS = 3'd3;
  localparam logic [2:0] ST_LINK = 3'd4;
  localparam logic [2:0] ST_PFX  = 3'd5;
  localparam logic [2:0] ST_END  = 3'd6;

  logic [AW-1:0] fc_mem [DICT_ENTRIES];
  logic [AW-1:0] ns_mem [DICT_ENTRIES];
  logic [7:0]    ec_mem [DICT_ENTRIES];

  logic [2:0]      state_q, state_d;
  logic [AW-1:0]   prefix_q, prefix_d;
  logic [7:0]      ch_q, ch_d;
  logic            last_q, last_d;
  logic [AW-1:0]   head_q, head_d;
  logic [AW-1:0]   node_q, node_d;
  logic [NF_W-1:0] nf_q, nf_d;
  logic [RC-1:0]   root_valid_q, root_valid_d;

  logic [AW-1:0] fc_rd_q, ns_rd_q;
  logic [7:0]    ec_rd_q;
  logic          fc_we, ent_we;
  logic [AW-1:0] fc_waddr, fc_wdata;
  logic [AW-1:0] walk_addr;
  logic [AW-1:0] head_node;
  logic          prefix_root;
  logic          head_ok, next_ok, dict_room;
  logic [2:0]    after_st;

  assign prefix_root = (prefix_q < AW'(RC));
  assign head_node   = (prefix_root && !root_valid_q[prefix_q[7:0]]) ? '0 : fc_rd_q;
  assign head_ok     = (head_node != '0) && (NF_W'(head_node) < NF_W'(DICT_ENTRIES));
  assign next_ok     = (ns_rd_q != '0) && (NF_W'(ns_rd_q) < NF_W'(DICT_ENTRIES));
  assign dict_room   = (nf_q < NF_W'(DICT_ENTRIES));
  assign after_st    = last_q ? ST_PFX : ST_IDLE;

  assign cmd_ready_o  = (state_q == ST_IDLE);
  assign code_valid_o = (state_q == ST_MISS) || (state_q == ST_PFX) || (state_q == ST_END);

  always_comb begin
    code_o.code = lzwe_pkg::MaxCodeW'(prefix_q);
    code_o.fin  = 1'b0;
    if (state_q == ST_END) begin
      code_o.code = lzwe_pkg::MaxCodeW'(lzwe_pkg::EndCode);
      code_o.fin  = 1'b1;
    end
  end

  always_comb begin
    state_d      = state_q;
    prefix_d     = prefix_q;
    ch_d         = ch_q;
    last_d       = last_q;
    head_d       = head_q;
    node_d       = node_q;
    nf_d         = nf_q;
    root_valid_d = root_valid_q;
    fc_we        = 1'b0;
    ent_we       = 1'b0;
    fc_waddr     = nf_q[AW-1:0];
    fc_wdata     = '0;
    walk_addr    = ns_rd_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          ch_d   = cmd_i.ch;
          last_d = cmd_i.last;
          if (cmd_i.start) begin
            prefix_d = AW'(cmd_i.ch);
            state_d  = cmd_i.last ? ST_PFX : ST_IDLE;
          end else begin
            state_d = ST_HEAD;
          end
        end
      end
      ST_HEAD: begin
        head_d    = head_node;
        node_d    = head_node;
        walk_addr = head_node;
        state_d   = head_ok ? ST_WALK : ST_MISS;
      end
      ST_WALK: begin
        if (ec_rd_q == ch_q) begin
          prefix_d = node_q;
          state_d  = after_st;
        end else if (next_ok) begin
          node_d = ns_rd_q;
        end else begin
          state_d = ST_MISS;
        end
      end
      ST_MISS: begin
        if (code_ready_i) begin
          if (dict_room) begin
            fc_we   = 1'b1;
            ent_we  = 1'b1;
            state_d = ST_LINK;
          end else begin
            prefix_d = AW'(ch_q);
            state_d  = after_st;
          end
        end
      end
      ST_LINK: begin
        fc_we    = 1'b1;
        fc_waddr = prefix_q;
        fc_wdata = nf_q[AW-1:0];
        if (prefix_root) begin
          root_valid_d[prefix_q[7:0]] = 1'b1;
        end
        nf_d     = nf_q + NF_W'(1);
        prefix_d = AW'(ch_q);
        state_d  = after_st;
      end
      ST_PFX: begin
        if (code_ready_i) begin
          state_d = ST_END;
        end
      end
      ST_END: begin
        if (code_ready_i) begin
          root_valid_d = '0;
          nf_d         = NF_W'(lzwe_pkg::FirstFree);
          prefix_d     = '0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      prefix_q     <= '0;
      nf_q         <= NF_W'(lzwe_pkg::FirstFree);
      root_valid_q <= '0;
    end else begin
      state_q      <= state_d;
      prefix_q     <= prefix_d;
      nf_q         <= nf_d;
      root_valid_q <= root_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    last_q <= last_d;
    head_q <= head_d;
    node_q <= node_d;
  end

  always_ff @(posedge clk_i) begin
    if (fc_we) begin
      fc_mem[fc_waddr] <= fc_wdata;
    end
    fc_rd_q <= fc_mem[prefix_q];
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ns_mem[nf_q[AW-1:0]] <= head_q;
      ec_mem[nf_q[AW-1:0]] <= ch_q;
    end
    ns_rd_q <= ns_mem[walk_addr];
    ec_rd_q <= ec_mem[walk_addr];
  end

endmodule

`default_nettype wire

[design/lzwe_pack.sv]
// Bit packer that turns codes into MSB-first bytes and pads the final byte.
`default_nettype none

module lzwe_pack #(
  parameter int unsigned CODE_WIDTH = 12
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                code_valid_i,
  output logic                     code_ready_o,
  input  wire lzwe_pkg::code_req_t code_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output lzwe_pkg::out_req_t       out_req_o
);

  localparam int unsigned ACC_W = CODE_WIDTH + 7;
  localparam int unsigned CNT_W = $clog2(ACC_W + 1);

  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               fin_q, fin_d;
  logic               out_valid_q, out_valid_d;
  lzwe_pkg::out_req_t out_q, out_d;
  logic               emit_ok, full_byte, pad_byte, take_code;

  assign emit_ok      = !out_valid_q || !out_stall_i;
  assign full_byte    = (cnt_q >= CNT_W'(8));
  assign pad_byte     = fin_q && !full_byte && (cnt_q != '0);
  assign code_ready_o = !full_byte && !fin_q;
  assign take_code    = code_valid_i && code_ready_o;
  assign out_valid_o  = out_valid_q;
  assign out_req_o    = out_q;

  always_comb begin
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    fin_d       = fin_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (take_code) begin
      acc_d = ACC_W'(acc_q << CODE_WIDTH) | ACC_W'(code_i.code[CODE_WIDTH-1:0]);
      cnt_d = cnt_q + CNT_W'(CODE_WIDTH);
      fin_d = code_i.fin;
    end else if (full_byte && emit_ok) begin
      out_d.out_byte = 8'(acc_q >> (cnt_q - CNT_W'(8)));
      out_d.out_last = fin_q && (cnt_q == CNT_W'(8));
      out_valid_d    = 1'b1;
      cnt_d          = cnt_q - CNT_W'(8);
      if (cnt_q == CNT_W'(8)) begin
        fin_d = 1'b0;
      end
    end else if (pad_byte && emit_ok) begin
      out_d.out_byte = 8'(acc_q << (CNT_W'(8) - cnt_q));
      out_d.out_last = 1'b1;
      out_valid_d    = 1'b1;
      cnt_d          = '0;
      fin_d          = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    out_q <= out_d;
  end

endmodule

`default_nettype wire

[design/lzw_encoder_12bit.sv]
// Top level of the LZW encoder with fixed-width codes and MSB-first byte packing.
//
//   port group   dir  handshake              payload
//   in_*         in   in_valid_i/in_stall_o  in_req_i  (in_byte, in_last)
//   out_*        out  out_valid_o/out_stall_i out_req_o (out_byte, out_last)
//
// The dictionary engine takes a byte that starts a message in its idle state.
// Any other byte reads the head and walks the siblings in the dictionary memory;
// a miss hands off a code and writes the link if there is room. A last byte adds
// two code handoffs. The packer drains one byte per cycle while not stalled.
// Reset clears the root flags at once, so no clearing pass follows it.
// The two-entry input queue takes bytes during an output stall until it is full.
`default_nettype none

module lzw_encoder_12bit #(
  parameter int unsigned DICT_ENTRIES = 4096,
  parameter int unsigned CODE_WIDTH   = 12
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire lzwe_pkg::in_req_t in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output lzwe_pkg::out_req_t     out_req_o
);

  logic                cmd_valid, cmd_ready;
  lzwe_pkg::cmd_t      cmd;
  logic                code_valid, code_ready;
  lzwe_pkg::code_req_t code;

  lzwe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  lzwe_dict #(
    .DICT_ENTRIES (DICT_ENTRIES)
  ) u_dict (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .code_valid_o (code_valid),
    .code_ready_i (code_ready),
    .code_o       (code)
  );

  lzwe_pack #(
    .CODE_WIDTH (CODE_WIDTH)
  ) u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .code_valid_i (code_valid),
    .code_ready_o (code_ready),
    .code_i       (code),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_req_o    (out_req_o)
  );

endmodule

`default_nettype wire

[design/lzwe_checker.sv]
// Port-level checker for the LZW encoder and its bind to the top level.
`default_nettype none
`include "lzw_encoder_12bit_defines.svh"

module lzwe_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire lzwe_pkg::in_req_t  in_req_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire lzwe_pkg::out_req_t out_req_o
);

  logic [3:0] open_q, open_d;
  logic       in_end, out_end;

  assign in_end  = in_valid_i && !in_stall_o && in_req_i.in_last;
  assign out_end = out_valid_o && !out_stall_i && out_req_o.out_last;

  always_comb begin
    open_d = open_q;
    if (in_end && !out_end && (open_q != 4'hF)) begin
      open_d = open_q + 4'd1;
    end else if (out_end && !in_end && (open_q != 4'd0)) begin
      open_d = open_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 4'd0;
    end else begin
      open_q <= open_d;
    end
  end

  `LZWE_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o), "stalled output request changed")
  `LZWE_ASSERT(a_end_matches, clk_i, rst_ni, out_end |-> (open_q != 4'd0), "final output byte without a finished input message")
  `LZWE_ASSERT_RST(a_quiet_reset, clk_i, !rst_ni |=> !out_valid_o, "output request right after reset")

endmodule

bind lzw_encoder_12bit lzwe_checker u_lzwe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_req_o   (out_req_o)
);

`default_nettype wire

[bench/lzw_encoder_12bit_test.sv]
// Self-checking bench for the 12-bit LZW encoder that predicts and compares each packed byte.
`timescale 1ns / 100ps

module lzw_encoder_12bit_test;

  localparam int unsigned DictSize   = 4096;
  localparam int unsigned CodeW      = 12;
  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned MaxReports = 10;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  lzwe_pkg::in_req_t  in_req_i;
  logic               out_valid_o;
  logic               out_stall_i;
  lzwe_pkg::out_req_t out_req_o;

  lzw_encoder_12bit #(
    .DICT_ENTRIES(DictSize),
    .CODE_WIDTH  (CodeW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

  // Encoder state as the bench predicts it.
  logic [11:0] dict_child [DictSize];
  logic [11:0] dict_sib   [DictSize];
  logic [7:0]  dict_char  [DictSize];
  bit          has_prefix;
  logic [11:0] cur_code;
  int unsigned free_code;
  logic [6:0]  bit_acc;
  int unsigned bit_cnt;

  lzwe_pkg::out_req_t step_bytes[$];
  lzwe_pkg::out_req_t expected_bytes[$];
  logic [7:0]         msg_buf[$];

  int unsigned mismatches;
  int unsigned checked_bytes;
  int unsigned sent_bytes;
  int unsigned msg_count;
  int unsigned idle_cycles;
  int unsigned hold_len_req;
  int unsigned hold_left;
  int unsigned stall_run;
  bit          tx_idle_on;
  bit          rx_idle_on;

  always #2 clk_i = ~clk_i;

  function automatic logic [11:0] find_child(input logic [11:0] parent, input logic [7:0] ch);
    logic [11:0] node;
    int unsigned guard;
    node  = dict_child[parent];
    guard = 0;
    while (node != 0 && guard < DictSize) begin
      if (dict_char[node] == ch) return node;
      node = dict_sib[node];
      guard++;
    end
    return 12'd0;
  endfunction

  task automatic pack_code(input logic [11:0] code);
    logic [18:0]        acc;
    int unsigned        cnt;
    lzwe_pkg::out_req_t ob;
    acc = {bit_acc, code};
    cnt = bit_cnt + CodeW;
    while (cnt >= 8) begin
      cnt         = cnt - 8;
      ob.out_byte = 8'(acc >> cnt);
      ob.out_last = 1'b0;
      step_bytes.push_back(ob);
    end
    bit_acc = 7'(acc & ((19'd1 << cnt) - 19'd1));
    bit_cnt = cnt;
  endtask

  task automatic clear_roots();
    for (int i = 0; i <= lzwe_pkg::RootCount; i++) dict_child[i] = 12'd0;
    free_code  = lzwe_pkg::FirstFree;
    has_prefix = 1'b0;
    cur_code   = 12'd0;
  endtask

  task automatic lzw_predict(input logic [7:0] ch, input logic is_last);
    logic [11:0]        hit;
    logic [7:0]         pad;
    lzwe_pkg::out_req_t ob;
    step_bytes.delete();
    if (!has_prefix) begin
      cur_code   = {4'd0, ch};
      has_prefix = 1'b1;
    end else begin
      hit = find_child(cur_code, ch);
      if (hit != 0) begin
        cur_code = hit;
      end else begin
        pack_code(cur_code);
        if (free_code < DictSize) begin
          dict_char[free_code]  = ch;
          dict_child[free_code] = 12'd0;
          dict_sib[free_code]   = dict_child[cur_code];
          dict_child[cur_code]  = 12'(free_code);
          free_code++;
        end
        cur_code = {4'd0, ch};
      end
    end
    if (is_last) begin
      pack_code(cur_code);
      pack_code(12'(lzwe_pkg::EndCode));
      if (bit_cnt > 0) begin
        pad         = {1'b0, bit_acc};
        pad         = pad << (8 - bit_cnt);
        ob.out_byte = pad;
        ob.out_last = 1'b0;
        step_bytes.push_back(ob);
      end
      bit_acc = 7'd0;
      bit_cnt = 0;
      ob = step_bytes[step_bytes.size() - 1];
      ob.out_last = 1'b1;
      step_bytes[step_bytes.size() - 1] = ob;
      clear_roots();
    end
    foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int unsigned gap;
    int unsigned pick;
    gap = 0;
    if (tx_idle_on) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) gap = 0;
      else if (pick < 95) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
    end
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    in_req_i.in_byte = b;
    in_req_i.in_last = is_last;
    do @(posedge clk_i); while (in_stall_o);
    lzw_predict(b, is_last);
    sent_bytes++;
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_buf.size(); i++) send_byte(msg_buf[i], i == msg_buf.size() - 1);
    msg_count++;
  endtask

  task automatic idle_input();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic fill_random_message(input int unsigned len, input bit narrow);
    logic [7:0] base;
    base = 8'($urandom_range(0, 255));
    msg_buf.delete();
    repeat (len) begin
      if (narrow) msg_buf.push_back(base + 8'($urandom_range(0, 3)));
      else msg_buf.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_until_drained();
    while (expected_bytes.size() != 0) @(posedge clk_i);
  endtask

  // A message of one byte emits its code and the end code with no padding.
  task automatic test_single_byte_messages();
    logic [7:0] vals[4];
    vals = '{8'h00, 8'hFF, 8'hA5, 8'h5A};
    foreach (vals[i]) begin
      msg_buf.delete();
      msg_buf.push_back(vals[i]);
      send_message();
    end
  endtask

  // A run of one byte value keeps hitting freshly added codes.
  task automatic test_repeated_byte();
    msg_buf.delete();
    repeat (7) msg_buf.push_back(8'h61);
    send_message();
  endtask

  // Two byte values in turn build new entries under both roots.
  task automatic test_alternating_pair();
    msg_buf.delete();
    repeat (4) begin
      msg_buf.push_back(8'h41);
      msg_buf.push_back(8'h42);
    end
    send_message();
  endtask

  // Three codes leave four bits over, so the final byte is zero padded.
  task automatic test_padded_tail();
    msg_buf.delete();
    msg_buf.push_back(8'h00);
    msg_buf.push_back(8'hFF);
    send_message();
  endtask

  task automatic test_random_messages();
    int unsigned start_bytes;
    int unsigned pick;
    int unsigned len;
    start_bytes = sent_bytes;
    while (sent_bytes - start_bytes < 100) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) len = 1;
      else if (pick < 80) len = $urandom_range(2, 12);
      else len = $urandom_range(13, 30);
      fill_random_message(len, $urandom_range(0, 3) != 0);
      send_message();
    end
  endtask

  // The receiver holds off long enough for the input side to stall.
  task automatic test_output_backpressure();
    tx_idle_on   = 1'b0;
    hold_len_req = 300;
    fill_random_message(40, 1'b1);
    send_message();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    fill_random_message(10, 1'b1);
    send_message();
    idle_input();
    wait_until_drained();
    fill_random_message(10, 1'b0);
    send_message();
  endtask

  always @(negedge clk_i) begin
    if (hold_len_req != 0) begin
      hold_left    = hold_len_req;
      hold_len_req = 0;
    end
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else if (stall_run > 0) begin
      stall_run--;
    end else if (!rx_idle_on) begin
      out_stall_i = 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0: begin
          out_stall_i = 1'b1;
          stall_run   = $urandom_range(10, 40);
        end
        1, 2, 3, 4, 5, 6: begin
          out_stall_i = 1'b1;
          stall_run   = $urandom_range(0, 3);
        end
        default: begin
          out_stall_i = 1'b0;
          stall_run   = $urandom_range(0, 6);
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    lzwe_pkg::out_req_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        if (mismatches < MaxReports) begin
          $display("Unexpected packed byte %02h (last %0b)", out_req_o.out_byte,
                   out_req_o.out_last);
        end
        mismatches++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_req_o.out_byte !== want.out_byte || out_req_o.out_last !== want.out_last) begin
          if (mismatches < MaxReports) begin
            $display("Packed byte %0d: expected %02h last %0b, got %02h last %0b",
                     checked_bytes, want.out_byte, want.out_last,
                     out_req_o.out_byte, out_req_o.out_last);
          end
          mismatches++;
        end
      end
      checked_bytes++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no request moved for %0d cycles", IdleLimit);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_req_i     = '0;
    out_stall_i  = 1'b0;
    mismatches   = 0;
    checked_bytes = 0;
    sent_bytes   = 0;
    msg_count    = 0;
    idle_cycles  = 0;
    hold_len_req = 0;
    hold_left    = 0;
    stall_run    = 0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    bit_acc      = 7'd0;
    bit_cnt      = 0;
    for (int i = 0; i < DictSize; i++) begin
      dict_child[i] = 12'd0;
      dict_sib[i]   = 12'd0;
      dict_char[i]  = 8'd0;
    end
    clear_roots();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_single_byte_messages();
    test_repeated_byte();
    test_alternating_pair();
    test_padded_tail();
    test_random_messages();
    test_output_backpressure();
    test_sender_pause();

    idle_input();
    wait_until_drained();
    repeat (40) @(posedge clk_i);
    $display("Encoded %0d messages from %0d input bytes; %0d packed bytes checked.",
             msg_count, sent_bytes, checked_bytes);
    $display("Covered short, repeated, alternating and padded messages, random traffic,");
    $display("a long output hold that stalls the input, and a sender pause.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
